// ===== rtl/bpmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmc_pkg
// Shared types and constants of the button press classifier and list cursor.
// ----------------------------------------------------------------------------
package bpmc_pkg;

  localparam int HEAD_W = 16;
  localparam int CNT_W  = 7;
  localparam int THR_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam int PAGE_ROWS_DEF = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam logic [THR_W-1:0] LONG_PUSH_RST   = 7'd10;
  localparam logic [THR_W-1:0] LONGER_PUSH_RST = 7'd30;
  localparam logic [THR_W-1:0] POWER_HOLD_RST  = 7'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PUSH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGER_PUSH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_HOLD  = 2'd2;

  typedef enum logic [1:0] {
    BTN_OPEN   = 2'd0,
    BTN_CENTER = 2'd1,
    BTN_UP     = 2'd2,
    BTN_MINUS  = 2'd3
  } button_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_OPEN        = 3'd1,
    EV_RANDOM_OPEN = 3'd2,
    EV_PAUSE       = 3'd3,
    EV_STOP        = 3'd4,
    EV_VOL_UP      = 3'd5,
    EV_VOL_DOWN    = 3'd6,
    EV_POWER_OFF   = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    MV_NONE      = 3'd0,
    MV_STEP_UP   = 3'd1,
    MV_STEP_DOWN = 3'd2,
    MV_PAGE_UP   = 3'd3,
    MV_PAGE_DOWN = 3'd4
  } move_t;

  typedef struct packed {
    event_t           ev;
    move_t            mv;
    logic [CNT_W-1:0] cnt_nxt;
  } classify_res_t;

endpackage

// ===== rtl/bpmc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmc_classify
// Press classifier: push, long push, long-long push and power-off hold.
// ----------------------------------------------------------------------------
module bpmc_classify import bpmc_pkg::*; (
  input  button_t          button,
  input  logic             player_mode,
  input  button_t          last_button,
  input  logic [CNT_W-1:0] repeat_count,
  input  logic [THR_W-1:0] long_push_ticks,
  input  logic [THR_W-1:0] longer_push_ticks,
  input  logic [THR_W-1:0] power_hold_ticks,
  output classify_res_t    res
);

  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = (repeat_count < CNT_MAX) ? repeat_count + CNT_W'(1) : repeat_count;

  always_comb begin
    res.ev      = EV_NONE;
    res.mv      = MV_NONE;
    res.cnt_nxt = repeat_count;
    priority if (button == BTN_OPEN) begin
      res.cnt_nxt = '0;
    end else if (last_button == BTN_OPEN) begin
      // first pressed tick
      unique case (button)
        BTN_CENTER: res.ev = player_mode ? EV_PAUSE : EV_OPEN;
        BTN_UP: begin
          if (player_mode) res.ev = EV_VOL_UP;
          else res.mv = MV_STEP_UP;
        end
        default: begin
          if (player_mode) res.ev = EV_VOL_DOWN;
          else res.mv = MV_STEP_DOWN;
        end
      endcase
    end else if (repeat_count == long_push_ticks) begin
      // up and minus keep the counter here so the action repeats while held
      unique case (button)
        BTN_CENTER: begin
          if (player_mode) res.ev = EV_STOP;
          res.cnt_nxt = cnt_inc;
        end
        BTN_UP: begin
          if (player_mode) res.ev = EV_VOL_UP;
          else res.mv = MV_PAGE_UP;
        end
        default: begin
          if (player_mode) res.ev = EV_VOL_DOWN;
          else res.mv = MV_PAGE_DOWN;
        end
      endcase
    end else if (repeat_count == longer_push_ticks) begin
      if (button == BTN_CENTER) res.ev = EV_RANDOM_OPEN;
      res.cnt_nxt = cnt_inc;
    end else if (repeat_count == power_hold_ticks) begin
      if (button == BTN_CENTER) res.ev = EV_POWER_OFF;
      res.cnt_nxt = cnt_inc;
    end else if (button == last_button) begin
      res.cnt_nxt = cnt_inc;
    end
  end

endmodule

// ===== rtl/bpmc_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmc_cursor
// Paged list cursor: step and page moves with clamping at the list ends.
// ----------------------------------------------------------------------------
module bpmc_cursor import bpmc_pkg::*; #(
  parameter int PAGE_ROWS = PAGE_ROWS_DEF,
  localparam int ROW_W = $clog2(PAGE_ROWS)
) (
  input  move_t             mv,
  input  logic              redraw,
  input  logic [HEAD_W-1:0] head,
  input  logic [ROW_W-1:0]  row,
  input  logic [HEAD_W-1:0] list_size,
  output logic [HEAD_W-1:0] head_nxt,
  output logic [ROW_W-1:0]  row_nxt,
  output logic              redraw_nxt
);

  localparam int SW = HEAD_W + 2;
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(PAGE_ROWS - 1);
  localparam logic [HEAD_W-1:0] PAGE_U   = HEAD_W'(PAGE_ROWS);
  localparam logic signed [SW-1:0] PAGE_S = SW'(PAGE_ROWS);

  logic signed [SW-1:0] hs, cs, ns, end_lim, sel_next, head_fwd;
  logic blk_end, blk_last, near_end, at_top, head_low, n_ge_page;
  logic down_ok, up_ok;

  // signed compares so short lists clamp like the integer form
  assign hs       = $signed({2'b00, head});
  assign cs       = $signed({{(SW-ROW_W){1'b0}}, row});
  assign ns       = $signed({2'b00, list_size});
  assign end_lim  = ns - PAGE_S;
  assign sel_next = hs + cs + SW'(1);
  assign head_fwd = hs + PAGE_S;

  assign blk_end   = (hs >= end_lim) && (row == ROW_LAST);
  assign blk_last  = sel_next >= ns;
  assign near_end  = head_fwd >= end_lim;
  assign at_top    = (head == '0) && (row == '0);
  assign head_low  = head < PAGE_U;
  assign n_ge_page = list_size >= PAGE_U;

  assign down_ok = !redraw && !blk_end && !blk_last;
  assign up_ok   = !redraw && !at_top;

  always_comb begin
    head_nxt   = head;
    row_nxt    = row;
    redraw_nxt = redraw;
    unique case (mv)
      MV_STEP_DOWN: begin
        if (down_ok) begin
          redraw_nxt = 1'b1;
          if (row == ROW_LAST) begin
            if (near_end) begin
              head_nxt = head + HEAD_W'(1);
            end else begin
              row_nxt  = '0;
              head_nxt = head + PAGE_U;
            end
          end else begin
            row_nxt = row + ROW_W'(1);
          end
        end
      end
      MV_STEP_UP: begin
        if (up_ok) begin
          redraw_nxt = 1'b1;
          if (row == '0) begin
            if (head_low) begin
              head_nxt = head - HEAD_W'(1);
            end else begin
              row_nxt  = ROW_LAST;
              head_nxt = head - PAGE_U;
            end
          end else begin
            row_nxt = row - ROW_W'(1);
          end
        end
      end
      MV_PAGE_DOWN: begin
        if (down_ok) begin
          redraw_nxt = 1'b1;
          if (near_end) begin
            // snap to the last page, then one step if the list fills a page
            head_nxt = list_size - PAGE_U;
            if (n_ge_page && row != ROW_LAST) row_nxt = row + ROW_W'(1);
          end else begin
            head_nxt = head + PAGE_U;
          end
        end
      end
      MV_PAGE_UP: begin
        if (up_ok) begin
          redraw_nxt = 1'b1;
          if (head_low) begin
            head_nxt = '0;
            if (row != '0) row_nxt = row - ROW_W'(1);
          end else begin
            head_nxt = head - PAGE_U;
          end
        end
      end
      default: begin
        head_nxt   = head;
        row_nxt    = row;
        redraw_nxt = redraw;
      end
    endcase
  end

endmodule

// ===== rtl/button_press_menu_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_menu_cursor
// Button press classifier with a paged file-list cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per polling tick (button, player mode, list size,
//           redraw acknowledge). Accepted when in_valid is high and
//           in_stall is low.
//   out_* : one word per tick: event code, cursor head and row, and the
//           redraw-pending flag. Taken when out_valid is high and out_stall
//           is low.
//   cfg_* : threshold writes (0 long push, 1 longer push, 2 power hold),
//           always ready; write only while the block is idle.
// An accepted word is held in the input register while the classify and
// cursor logic feeds the result register, which loads it once the result
// slot is free or being taken.
// One word per cycle is sustained while out_stall stays low; the counter and
// cursor state is updated as each result loads.
// Reset clears both stages, sets cursor to 0, marks a redraw pending and
// loads the default thresholds. A stall on the result side holds the result
// register and the input register; in_stall rises only once the input
// register is full and cannot move on.
// ----------------------------------------------------------------------------
module button_press_menu_cursor import bpmc_pkg::*; #(
  parameter int PAGE_ROWS = PAGE_ROWS_DEF,
  localparam int ROW_W = $clog2(PAGE_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_button,
  input  logic                 in_player_mode,
  input  logic [HEAD_W-1:0]    in_list_size,
  input  logic                 in_redraw_ack,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_event_res,
  output logic [HEAD_W-1:0]    out_cursor_head,
  output logic [ROW_W-1:0]     out_cursor_row,
  output logic                 out_redraw_pending_out,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  logic [THR_W-1:0] long_push_r, longer_push_r, power_hold_r;

  logic              s1_valid_r;
  button_t           s1_button_r;
  logic              s1_play_r;
  logic [HEAD_W-1:0] s1_size_r;
  logic              s1_ack_r;

  button_t           last_btn_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HEAD_W-1:0] head_r;
  logic [ROW_W-1:0]  row_r;
  logic              rp_r;

  logic              out_valid_r;
  event_t            out_event_r;

  logic              s1_adv, s1_fire, in_fire, rp_acked;
  classify_res_t     cls;
  logic [HEAD_W-1:0] head_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic              rp_nxt;

  assign cfg_ready = 1'b1;

  // input register moves on whenever the result slot is free or being taken
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;
  assign rp_acked = rp_r && !s1_ack_r;

  bpmc_classify u_classify (
    .button            (s1_button_r),
    .player_mode       (s1_play_r),
    .last_button       (last_btn_r),
    .repeat_count      (cnt_r),
    .long_push_ticks   (long_push_r),
    .longer_push_ticks (longer_push_r),
    .power_hold_ticks  (power_hold_r),
    .res               (cls)
  );

  bpmc_cursor #(.PAGE_ROWS(PAGE_ROWS)) u_cursor (
    .mv         (cls.mv),
    .redraw     (rp_acked),
    .head       (head_r),
    .row        (row_r),
    .list_size  (s1_size_r),
    .head_nxt   (head_nxt),
    .row_nxt    (row_nxt),
    .redraw_nxt (rp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_push_r   <= LONG_PUSH_RST;
      longer_push_r <= LONGER_PUSH_RST;
      power_hold_r  <= POWER_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LONG_PUSH:   long_push_r   <= cfg_data;
        CFG_LONGER_PUSH: longer_push_r <= cfg_data;
        CFG_POWER_HOLD:  power_hold_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_button_r <= button_t'(in_button);
      s1_play_r   <= in_player_mode;
      s1_size_r   <= in_list_size;
      s1_ack_r    <= in_redraw_ack;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_btn_r  <= BTN_OPEN;
      cnt_r       <= '0;
      head_r      <= '0;
      row_r       <= '0;
      rp_r        <= 1'b1;
      out_valid_r <= 1'b0;
      out_event_r <= EV_NONE;
    end else begin
      if (s1_fire) begin
        last_btn_r  <= s1_button_r;
        cnt_r       <= cls.cnt_nxt;
        head_r      <= head_nxt;
        row_r       <= row_nxt;
        rp_r        <= rp_nxt;
        out_event_r <= cls.ev;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cursor state only changes when a new result is loaded, so it is the payload
  assign out_valid              = out_valid_r;
  assign out_event_res          = out_event_r;
  assign out_cursor_head        = head_r;
  assign out_cursor_row         = row_r;
  assign out_redraw_pending_out = rp_r;

  a_row_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(row_r) < PAGE_ROWS))
    else $error("cursor row outside the page");

  a_move_sets_redraw: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != $past(head_r) || row_r != $past(row_r)) |-> rp_r)
    else $error("cursor moved without a pending redraw");

  a_release_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_button_r == BTN_OPEN) |=> (cnt_r == '0))
    else $error("repeat counter not cleared on release");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/sv/button_press_menu_cursor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_menu_cursor_test
// Drives polling ticks into the button classifier and list cursor, predicts
// the event, cursor and redraw flag of every tick in the bench, and compares
// each result word in order. Directed ticks come first, then phases of held
// button sequences under several threshold settings, with random gaps and
// result stalls in all but the last phase.
// ----------------------------------------------------------------------------
module button_press_menu_cursor_test;
  import bpmc_pkg::*;

  localparam int PAGE = PAGE_ROWS_DEF;
  localparam int ROW_W = $clog2(PAGE_ROWS_DEF);

  typedef struct {
    event_t      ev;
    logic [15:0] head;
    logic [2:0]  row;
    bit          pend;
  } tick_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_button;
  logic                 in_player_mode;
  logic [HEAD_W-1:0]    in_list_size;
  logic                 in_redraw_ack;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_event_res;
  logic [HEAD_W-1:0]    out_cursor_head;
  logic [ROW_W-1:0]     out_cursor_row;
  logic                 out_redraw_pending_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0]     cfg_data;

  // predicted block state
  logic [THR_W-1:0] long_thr;
  logic [THR_W-1:0] longer_thr;
  logic [THR_W-1:0] power_thr;
  button_t          prev_button;
  logic [CNT_W-1:0] hold_count;
  logic [15:0]      cur_head;
  logic [2:0]       cur_row;
  bit               redraw_due;

  tick_result_t predicted_results[$];
  int           ticks_sent;
  int           n_fail;
  bit           idle_on;

  button_press_menu_cursor DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_button              (in_button),
    .in_player_mode         (in_player_mode),
    .in_list_size           (in_list_size),
    .in_redraw_ack          (in_redraw_ack),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_event_res          (out_event_res),
    .out_cursor_head        (out_cursor_head),
    .out_cursor_row         (out_cursor_row),
    .out_redraw_pending_out (out_redraw_pending_out),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // ------------------------------------------------------------------------
  // cursor and classifier prediction
  // ------------------------------------------------------------------------
  function automatic void bump_hold();
    if (hold_count < CNT_MAX) hold_count = hold_count + 1'b1;
  endfunction

  function automatic void cursor_step_down(int n);
    int h;
    int c;
    h = int'(cur_head);
    c = int'(cur_row);
    if (redraw_due) return;
    if (h >= n - PAGE && c == PAGE - 1) return;
    if (h + c + 1 >= n) return;
    redraw_due = 1'b1;
    c++;
    if (c >= PAGE) begin
      if (h + PAGE >= n - PAGE) begin
        c = PAGE - 1;
        h++;
      end else begin
        c = 0;
        h += PAGE;
      end
    end
    cur_head = h[15:0];
    cur_row = c[2:0];
  endfunction

  function automatic void cursor_step_up();
    int h;
    int c;
    h = int'(cur_head);
    c = int'(cur_row);
    if (redraw_due) return;
    if (h == 0 && c == 0) return;
    redraw_due = 1'b1;
    if (c == 0) begin
      if (h - PAGE < 0) begin
        h--;
      end else begin
        c = PAGE - 1;
        h -= PAGE;
      end
    end else begin
      c--;
    end
    cur_head = h[15:0];
    cur_row = c[2:0];
  endfunction

  function automatic void cursor_page_down(int n);
    int h;
    int c;
    int t;
    h = int'(cur_head);
    c = int'(cur_row);
    if (redraw_due) return;
    if (h >= n - PAGE && c == PAGE - 1) return;
    if (h + c + 1 >= n) return;
    if (h + PAGE >= n - PAGE) begin
      // near the end: jump to the last page, which may wrap on a short list
      t = n - PAGE;
      cur_head = t[15:0];
      cursor_step_down(n);
    end else begin
      t = h + PAGE;
      cur_head = t[15:0];
    end
    redraw_due = 1'b1;
  endfunction

  function automatic void cursor_page_up();
    int h;
    int c;
    int t;
    h = int'(cur_head);
    c = int'(cur_row);
    if (redraw_due) return;
    if (h == 0 && c == 0) return;
    if (h - PAGE < 0) begin
      cur_head = '0;
      cursor_step_up();
    end else begin
      t = h - PAGE;
      cur_head = t[15:0];
    end
    redraw_due = 1'b1;
  endfunction

  function automatic tick_result_t classify_tick(button_t b, bit play, logic [15:0] size,
                                                 bit ack);
    tick_result_t r;
    int n;
    n = int'(size);
    r.ev = EV_NONE;
    if (ack) redraw_due = 1'b0;
    if (b == BTN_OPEN) begin
      hold_count = '0;
    end else if (prev_button == BTN_OPEN) begin
      if (b == BTN_CENTER) begin
        if (play) r.ev = EV_PAUSE;
        else r.ev = EV_OPEN;
      end else if (b == BTN_UP) begin
        if (play) r.ev = EV_VOL_UP;
        else cursor_step_up();
      end else begin
        if (play) r.ev = EV_VOL_DOWN;
        else cursor_step_down(n);
      end
    end else if (hold_count == long_thr) begin
      // up and minus do not count here, so they repeat while held
      if (b == BTN_CENTER) begin
        if (play) r.ev = EV_STOP;
        bump_hold();
      end else if (b == BTN_UP) begin
        if (play) r.ev = EV_VOL_UP;
        else cursor_page_up();
      end else begin
        if (play) r.ev = EV_VOL_DOWN;
        else cursor_page_down(n);
      end
    end else if (hold_count == longer_thr) begin
      if (b == BTN_CENTER) r.ev = EV_RANDOM_OPEN;
      bump_hold();
    end else if (hold_count == power_thr) begin
      if (b == BTN_CENTER) r.ev = EV_POWER_OFF;
      bump_hold();
    end else if (b == prev_button) begin
      bump_hold();
    end
    prev_button = b;
    r.head = cur_head;
    r.row = cur_row;
    r.pend = redraw_due;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  task automatic send_tick(button_t b, bit play, logic [15:0] size, bit ack);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_button <= b;
    in_player_mode <= play;
    in_list_size <= size;
    in_redraw_ack <= ack;
    do @(posedge clk); while (in_stall);
    predicted_results.push_back(classify_tick(b, play, size, ack));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_word(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LONG_PUSH) long_thr = val;
    else if (idx == CFG_LONGER_PUSH) longer_thr = val;
    else if (idx == CFG_POWER_HOLD) power_thr = val;
    @(negedge clk);
  endtask

  task automatic set_thresholds(logic [THR_W-1:0] lp, logic [THR_W-1:0] lgp,
                                logic [THR_W-1:0] ph);
    wait_idle();
    cfg_word(CFG_LONG_PUSH, lp);
    cfg_word(CFG_LONGER_PUSH, lgp);
    cfg_word(CFG_POWER_HOLD, ph);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_list_size();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3) return 16'($urandom_range(0, 12));
    else if (r <= 6) return 16'($urandom_range(13, 300));
    else if (r == 7) return 16'hFFFF;
    else if (r == 8) return 16'($urandom_range(65520, 65535));
    else return 16'($urandom);
  endfunction

  // result side: stall bursts
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    tick_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        w = predicted_results.pop_front();
        if (out_event_res !== w.ev) begin
          $error("event_res: expected %0d, got %0d", w.ev, out_event_res);
          n_fail++;
        end
        if (out_cursor_head !== w.head) begin
          $error("cursor_head: expected %0d, got %0d", w.head, out_cursor_head);
          n_fail++;
        end
        if (out_cursor_row !== w.row[ROW_W-1:0]) begin
          $error("cursor_row: expected %0d, got %0d", w.row, out_cursor_row);
          n_fail++;
        end
        if (out_redraw_pending_out !== w.pend) begin
          $error("redraw_pending_out: expected %0d, got %0d", w.pend,
                 out_redraw_pending_out);
          n_fail++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_push_events();
    send_tick(BTN_OPEN, 1'b0, 16'd0, 1'b0);
    // redraw still pending from reset, so the move is dropped
    send_tick(BTN_MINUS, 1'b0, 16'hFFFF, 1'b0);
    send_tick(BTN_OPEN, 1'b0, 16'hFFFF, 1'b1);
    send_tick(BTN_MINUS, 1'b0, 16'hFFFF, 1'b1);
    send_tick(BTN_OPEN, 1'b0, 16'hFFFF, 1'b0);
    send_tick(BTN_UP, 1'b0, 16'hFFFF, 1'b1);
    send_tick(BTN_CENTER, 1'b0, 16'hFFFF, 1'b0);
    send_tick(BTN_OPEN, 1'b1, 16'd0, 1'b0);
    send_tick(BTN_CENTER, 1'b1, 16'd0, 1'b0);
    send_tick(BTN_OPEN, 1'b1, 16'd0, 1'b0);
    send_tick(BTN_UP, 1'b1, 16'd0, 1'b0);
    send_tick(BTN_OPEN, 1'b1, 16'd0, 1'b0);
    send_tick(BTN_MINUS, 1'b1, 16'd0, 1'b0);
  endtask

  task automatic test_short_list_wrap();
    // zero long threshold: the second held tick pages down on a 2-entry list
    set_thresholds(7'd0, 7'd1, 7'd2);
    send_tick(BTN_OPEN, 1'b0, 16'd2, 1'b0);
    send_tick(BTN_MINUS, 1'b0, 16'd2, 1'b0);
    send_tick(BTN_MINUS, 1'b0, 16'd2, 1'b1);
    send_tick(BTN_MINUS, 1'b0, 16'd2, 1'b1);
  endtask

  task automatic test_hold_thresholds();
    set_thresholds(7'd2, 7'd4, 7'd6);
    send_tick(BTN_OPEN, 1'b1, 16'hFFFF, 1'b1);
    repeat (7) send_tick(BTN_CENTER, 1'b1, 16'hFFFF, 1'b1);
  endtask

  task automatic test_random_holds(int n_ticks, logic [THR_W-1:0] lp,
                                   logic [THR_W-1:0] lgp, logic [THR_W-1:0] ph);
    int stop_at;
    int r;
    int len;
    int thr;
    button_t b;
    bit play;
    logic [15:0] size;
    set_thresholds(lp, lgp, ph);
    stop_at = ticks_sent + n_ticks;
    size = pick_list_size();
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(button_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) == 0) size = pick_list_size();
        b = button_t'($urandom_range(1, 3));
        play = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        if (r <= 4) begin
          len = $urandom_range(1, 4);
        end else if (r <= 8) begin
          // hold just past one of the thresholds
          case ($urandom_range(0, 2))
            0: thr = int'(long_thr);
            1: thr = int'(longer_thr);
            default: thr = int'(power_thr);
          endcase
          len = thr + $urandom_range(1, 4);
        end else begin
          // long holds, near the point where the counter saturates
          len = $urandom_range(120, 135);
        end
        repeat (len) send_tick(b, play, size, 1'($urandom_range(0, 1)));
        // mostly release, sometimes switch buttons while held
        if ($urandom_range(0, 7) != 0)
          repeat ($urandom_range(1, 3))
            send_tick(BTN_OPEN, play, size, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_button = BTN_OPEN;
    in_player_mode = 1'b0;
    in_list_size = '0;
    in_redraw_ack = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LONG_PUSH;
    cfg_data = '0;
    n_fail = 0;
    ticks_sent = 0;
    idle_on = 1'b1;
    long_thr = LONG_PUSH_RST;
    longer_thr = LONGER_PUSH_RST;
    power_thr = POWER_HOLD_RST;
    prev_button = BTN_OPEN;
    hold_count = '0;
    cur_head = '0;
    cur_row = '0;
    redraw_due = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_push_events();
    test_short_list_wrap();
    test_hold_thresholds();
    test_random_holds(150, LONG_PUSH_RST, LONGER_PUSH_RST, POWER_HOLD_RST);
    test_random_holds(120, THR_W'($urandom_range(1, 12)), THR_W'($urandom_range(1, 12)),
                      THR_W'($urandom_range(1, 12)));
    test_random_holds(80, 7'd1, 7'd1, 7'd1);
    test_random_holds(100, 7'd127, 7'd127, 7'd127);
    test_random_holds(120, THR_W'($urandom_range(1, 127)), THR_W'($urandom_range(1, 127)),
                      THR_W'($urandom_range(1, 127)));
    test_random_holds(120, THR_W'($urandom_range(1, 12)), THR_W'($urandom_range(1, 12)),
                      THR_W'($urandom_range(1, 12)));
    test_random_holds(80, 7'd0, 7'd2, 7'd127);
    wait_idle();
    idle_on = 1'b0;
    test_random_holds(150, THR_W'($urandom_range(1, 12)), THR_W'($urandom_range(1, 12)),
                      THR_W'($urandom_range(1, 12)));

    wait_idle();
    repeat (10) @(posedge clk);
    if (n_fail == 0 && predicted_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
